@@ hw/rtl/tivs_pkg.sv @@
// Shared types and constants for the timed ignition valve sequencer.
package tivs_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned EVENT_W = 24;
  localparam int unsigned DLY_S_W = 8;
  // 255 s * 1000 = 255000 fits in 18 bits
  localparam int unsigned DLY_MS_W = 18;
  localparam int unsigned MS_PER_S = 1000;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_SAFEOFF = 3'd1,
    CMD_RELIEF  = 3'd2,
    CMD_PUMP    = 3'd3,
    CMD_FIRE    = 3'd4
  } cmd_t;

  typedef enum logic [0:0] {
    REG_ERROR_MASK = 1'b0,
    REG_LINK_MASK  = 1'b1
  } reg_idx_t;

  // Drive word, one bit per actuator
  typedef struct packed {
    logic igniter;
    logic relief;
    logic lock;
    logic pump;
  } drive_t;

  localparam drive_t DRV_OFF    = '{igniter: 1'b0, relief: 1'b0, lock: 1'b0, pump: 1'b0};
  localparam drive_t DRV_PUMP   = '{igniter: 1'b0, relief: 1'b0, lock: 1'b0, pump: 1'b1};
  localparam drive_t DRV_RELIEF = '{igniter: 1'b0, relief: 1'b1, lock: 1'b0, pump: 1'b0};

  function automatic logic [DLY_MS_W-1:0] sec_to_ms(input logic [DLY_S_W-1:0] s);
    sec_to_ms = DLY_MS_W'({{(DLY_MS_W-DLY_S_W){1'b0}}, s} * DLY_MS_W'(MS_PER_S));
  endfunction

endpackage

@@ hw/rtl/timed_ignition_valve_sequencer.sv @@
// Top level of the timed ignition valve sequencer: input stage, sequencing logic, result stage.
//
// Every input transaction (a refresh tick or a command) yields exactly one output
// transaction carrying the four actuator drives, the LED snapshot and a copy of the
// timestamp. Commands: safe off, relief, pump only, fire; codes 5..7 act as ticks.
// A fire command records now_ms as its start time and runs the pump; the igniter comes
// on once igniter_delay_s seconds have elapsed, the lock valve once lock_delay_s seconds
// have elapsed (only when user_enable was set on the command). A nonzero fire_length_ms
// ends the sequence after that many ms, leaving only the pump on. Elapsed time is
// now_ms minus start time, modulo 2^32, so timestamp wrap is handled. Relief forces the
// relief valve on and all other drives off. The very first transaction after reset
// latches safety_lock into mode_led if it is a tick; every command sets mode_led to user_enable.
// Timing: two-stage pipeline (input register, result register), one transaction per clock
// while out_ready holds. The registers are decoupled, so a new transaction is taken into an
// empty input register while a finished result waits on out_ready. The delay seconds-to-ms
// conversion is done on the way into the input register; sequencing state updates as the
// item leaves it. Masks are written through cfg_write/cfg_index/cfg_data; the user must
// write them only while the block is idle, which the block itself does not enforce.
module timed_ignition_valve_sequencer
  import tivs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_write,
  input  logic [0:0]          cfg_index,
  input  logic [EVENT_W-1:0]  cfg_data,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          cmd,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic                user_enable,
  input  logic [DLY_S_W-1:0]  igniter_delay_s,
  input  logic [DLY_S_W-1:0]  lock_delay_s,
  input  logic [TIME_W-1:0]   fire_length_ms,
  input  logic [EVENT_W-1:0]  event_bits,
  input  logic                safety_lock,
  // output channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                pump_on,
  output logic                lock_valve_on,
  output logic                relief_open,
  output logic                igniter_pwr,
  output logic                error_led,
  output logic                pump_led,
  output logic                link_led,
  output logic                power_led,
  output logic                mode_led,
  output logic                firing,
  output logic                relieving,
  output logic [TIME_W-1:0]   stamp_ms
);

  // configuration registers
  logic [EVENT_W-1:0] error_led_mask;
  logic [EVENT_W-1:0] link_online_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_led_mask   <= '0;
      link_online_mask <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ERROR_MASK: error_led_mask   <= cfg_data;
        REG_LINK_MASK:  link_online_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  logic                s1_valid;
  logic [2:0]          s1_cmd;
  logic [TIME_W-1:0]   s1_now;
  logic                s1_user;
  logic [DLY_MS_W-1:0] s1_ign_ms;
  logic [DLY_MS_W-1:0] s1_lock_ms;
  logic [TIME_W-1:0]   s1_len;
  logic [EVENT_W-1:0]  s1_event;
  logic                s1_safety;
  logic                s1_adv;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd     <= cmd;
      s1_now     <= now_ms;
      s1_user    <= user_enable;
      s1_ign_ms  <= sec_to_ms(igniter_delay_s);
      s1_lock_ms <= sec_to_ms(lock_delay_s);
      s1_len     <= fire_length_ms;
      s1_event   <= event_bits;
      s1_safety  <= safety_lock;
    end
  end

  // sequencing state
  logic                held_user_mode;
  logic [DLY_MS_W-1:0] held_ign_ms;
  logic [DLY_MS_W-1:0] held_lock_ms;
  logic [TIME_W-1:0]   held_fire_length;
  logic [TIME_W-1:0]   start_time;
  logic                fire_flag;
  logic                relief_flag;
  drive_t              drive_bits;
  logic                mode_latch;
  logic                latch_done;

  logic                held_user_mode_next;
  logic [DLY_MS_W-1:0] held_ign_ms_next;
  logic [DLY_MS_W-1:0] held_lock_ms_next;
  logic [TIME_W-1:0]   held_fire_length_next;
  logic [TIME_W-1:0]   start_time_next;
  logic                fire_flag_next;
  logic                relief_flag_next;
  drive_t              drive_bits_next;
  logic                mode_latch_next;
  logic                is_cmd;
  logic [TIME_W-1:0]   elapsed;
  drive_t              fire_drv;

  always_comb begin
    held_user_mode_next   = held_user_mode;
    held_ign_ms_next      = held_ign_ms;
    held_lock_ms_next     = held_lock_ms;
    held_fire_length_next = held_fire_length;
    start_time_next       = start_time;
    fire_flag_next        = fire_flag;
    relief_flag_next      = relief_flag;
    drive_bits_next       = drive_bits;
    mode_latch_next       = latch_done ? mode_latch : s1_safety;
    is_cmd                = 1'b1;

    case (cmd_t'(s1_cmd))
      CMD_SAFEOFF: begin
        fire_flag_next   = 1'b0;
        relief_flag_next = 1'b0;
        drive_bits_next  = DRV_OFF;
      end
      CMD_RELIEF: begin
        fire_flag_next   = 1'b0;
        relief_flag_next = 1'b1;
        drive_bits_next  = DRV_RELIEF;
      end
      CMD_PUMP: begin
        fire_flag_next   = 1'b0;
        relief_flag_next = 1'b0;
        drive_bits_next  = DRV_PUMP;
      end
      CMD_FIRE: begin
        fire_flag_next   = 1'b1;
        relief_flag_next = 1'b0;
        start_time_next  = s1_now;
        drive_bits_next  = DRV_PUMP;
      end
      default: is_cmd = 1'b0;   // tick or unused code
    endcase

    if (is_cmd) begin
      held_user_mode_next   = s1_user;
      held_ign_ms_next      = s1_ign_ms;
      held_lock_ms_next     = s1_lock_ms;
      held_fire_length_next = s1_len;
      mode_latch_next       = s1_user;
    end

    // fire timing against the (possibly just updated) held values
    elapsed  = s1_now - start_time_next;
    fire_drv = DRV_PUMP;
    if (elapsed >= TIME_W'(held_ign_ms_next)) fire_drv.igniter = 1'b1;
    if (held_user_mode_next && elapsed >= TIME_W'(held_lock_ms_next)) fire_drv.lock = 1'b1;

    if (fire_flag_next) begin
      if (held_fire_length_next != '0 && elapsed >= held_fire_length_next) begin
        fire_flag_next  = 1'b0;
        drive_bits_next = DRV_PUMP;
      end else begin
        drive_bits_next = fire_drv;
      end
    end

    if (relief_flag_next) drive_bits_next = DRV_RELIEF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_user_mode   <= 1'b0;
      held_ign_ms      <= '0;
      held_lock_ms     <= '0;
      held_fire_length <= '0;
      start_time       <= '0;
      fire_flag        <= 1'b0;
      relief_flag      <= 1'b0;
      drive_bits       <= DRV_OFF;
      mode_latch       <= 1'b0;
      latch_done       <= 1'b0;
    end else if (s1_adv) begin
      held_user_mode   <= held_user_mode_next;
      held_ign_ms      <= held_ign_ms_next;
      held_lock_ms     <= held_lock_ms_next;
      held_fire_length <= held_fire_length_next;
      start_time       <= start_time_next;
      fire_flag        <= fire_flag_next;
      relief_flag      <= relief_flag_next;
      drive_bits       <= drive_bits_next;
      mode_latch       <= mode_latch_next;
      latch_done       <= 1'b1;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pump_on       <= drive_bits_next.pump;
      lock_valve_on <= drive_bits_next.lock;
      relief_open   <= drive_bits_next.relief;
      igniter_pwr   <= drive_bits_next.igniter;
      error_led     <= |(s1_event & error_led_mask);
      link_led      <= |(s1_event & link_online_mask);
      mode_led      <= mode_latch_next;
      firing        <= fire_flag_next;
      relieving     <= relief_flag_next;
      stamp_ms      <= s1_now;
    end
  end

  assign pump_led  = pump_on;
  assign power_led = 1'b1;

  // checks
  a_relief_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && relieving |-> relief_open && !pump_on && !lock_valve_on && !igniter_pwr)
    else $error("relief active with another drive on");

  a_fire_relief: assert property (@(posedge clk) disable iff (rst)
    !(fire_flag && relief_flag))
    else $error("fire and relief both active");

  a_ignite_in_fire: assert property (@(posedge clk) disable iff (rst)
    out_valid && (igniter_pwr || lock_valve_on) |-> firing && pump_on)
    else $error("igniter or lock valve on outside a fire sequence");

  a_lock_user: assert property (@(posedge clk) disable iff (rst)
    out_valid && lock_valve_on |-> held_user_mode)
    else $error("lock valve opened without user mode");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid)
    else $error("input stalled with free pipeline slot");

endmodule
